// ===== rtl/rgbsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbsm_pkg
// Types, register indexes and arithmetic helpers of the RGB frame smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbsm_pkg;

  // Blend weights of the temporal filter, out of 256
  localparam logic [7:0] BLEND_CUR  = 8'd180;
  localparam logic [7:0] BLEND_PREV = 8'd76;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPORAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL  = 2'd1;

  // Red in the low byte
  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgb_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_CTR,
    ST_RD_RIGHT,
    ST_RESULT,
    ST_FL_RD,
    ST_FL_OUT
  } state_e;

  function automatic logic [7:0] blend8(input logic [7:0] cur, input logic [7:0] prev);
    logic [15:0] s;
    s = 16'(cur) * 16'(BLEND_CUR) + 16'(prev) * 16'(BLEND_PREV);
    return s[15:8];
  endfunction

  // (4*centre + up + down + left + right) / 8
  function automatic logic [7:0] blur8(input logic [7:0] ctr, input logic [7:0] up,
                                       input logic [7:0] dn, input logic [7:0] lf,
                                       input logic [7:0] rt);
    logic [10:0] s;
    s = (11'(ctr) << 2) + 11'(up) + 11'(dn) + 11'(lf) + 11'(rt);
    return s[10:3];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb_frame_temporal_spatial_smoother.sv =====
// ----------------------------------------------------------------------------
// rgb_frame_temporal_spatial_smoother
// Temporal blend with the previous frame, then a five-point blur.
// ----------------------------------------------------------------------------
// Pixels of a WIDTH x HEIGHT RGB888 frame enter on the s_axis channel in
// raster order. Each is blended with the raw pixel of the previous frame
// (when temporal_enable) and kept in a two-row line buffer. Results leave on
// m_axis one row behind: the input at row r >= 1, column c gives the output
// at row r-1, column c. Row 0 inputs give no output. The last pixel of a frame
// also flushes the final row; m_axis_tlast marks the last pixel of the frame.
// Sequence: three reads go through the single read port of the line buffer:
// up as the pixel is accepted, then centre, then right; the result is then
// registered. A frame-end flush reads and outputs each pixel of the last row.
// A full output register holds off the result cycle, so m_axis_tready low
// stalls the input side once one item waits. After reset the previous-frame
// memory is cleared with s_axis_tready low; config writes are taken at any
// time. Both enables reset to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_frame_temporal_spatial_smoother
  import rgbsm_pkg::*;
#(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned HEIGHT = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // config write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic                 cfg_data_i,
  // pixel input
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [23:0]          s_axis_tdata,  // red_in, green_in, blue_in
  // pixel output
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [23:0]               m_axis_tdata,  // red_out, green_out, blue_out
  output logic                      m_axis_tlast   // frame_end
);

  localparam int unsigned COL_W    = $clog2(WIDTH);
  localparam int unsigned ROW_W    = $clog2(HEIGHT);
  localparam int unsigned PIX_N    = WIDTH * HEIGHT;
  localparam int unsigned PIX_W    = $clog2(PIX_N);
  localparam int unsigned RS_DEPTH = 2 << COL_W;
  localparam int unsigned RS_AW    = COL_W + 1;
  localparam logic        LAST_SLOT = 1'((HEIGHT - 1) % 2);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(HEIGHT - 1);

  state_e state_q, state_d;

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [PIX_W-1:0] pix_q;
  logic [PIX_W-1:0] clr_q;
  logic [COL_W-1:0] fl_x_q;
  logic             te_q, se_q, te_item_q;
  rgb_t             cur_q, up_q, ctr_q, left_q, val_q;
  logic             out_valid_q, out_last_q;
  rgb_t             out_px_q;

  // memory ports
  logic             pf_we, pf_re;
  logic [PIX_W-1:0] pf_waddr;
  rgb_t             pf_wdata, pf_rdata;
  logic             rs_we, rs_re;
  logic [RS_AW-1:0] rs_waddr, rs_raddr;
  rgb_t             rs_rdata;

  logic out_free, res_go, fl_go, last_pix, interior, slot;
  rgb_t blend_px, blur_px;

  assign slot     = row_q[0];
  assign out_free = !out_valid_q || m_axis_tready;
  assign last_pix = (row_q == LAST_ROW) && (col_q == LAST_COL);
  assign interior = se_q && (row_q >= ROW_W'(2)) && (col_q != '0) && (col_q != LAST_COL);

  rgbsm_ram #(
    .DATA_W ($bits(rgb_t)),
    .DEPTH  (PIX_N)
  ) u_prev_frame (
    .clk_i   (clk_i),
    .we_i    (pf_we),
    .waddr_i (pf_waddr),
    .wdata_i (pf_wdata),
    .re_i    (pf_re),
    .raddr_i (pix_q),
    .rdata_o (pf_rdata)
  );

  rgbsm_ram #(
    .DATA_W ($bits(rgb_t)),
    .DEPTH  (RS_DEPTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (val_q),
    .re_i    (rs_re),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (clr_q == PIX_W'(PIX_N - 1)) state_d = ST_IDLE;
      ST_IDLE:     if (s_axis_tvalid) state_d = ST_RD_CTR;
      ST_RD_CTR:   state_d = ST_RD_RIGHT;
      ST_RD_RIGHT: state_d = ST_RESULT;
      ST_RESULT: begin
        if (res_go) state_d = last_pix ? ST_FL_RD : ST_IDLE;
      end
      ST_FL_RD:    state_d = ST_FL_OUT;
      ST_FL_OUT: begin
        if (fl_go) state_d = (fl_x_q == LAST_COL) ? ST_IDLE : ST_FL_RD;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    pf_re    = 1'b0;
    pf_we    = 1'b0;
    pf_waddr = pix_q;
    pf_wdata = cur_q;
    rs_re    = 1'b0;
    rs_raddr = {slot, col_q};
    rs_we    = 1'b0;
    rs_waddr = {slot, col_q};
    res_go   = 1'b0;
    fl_go    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        pf_we    = 1'b1;
        pf_waddr = clr_q;
        pf_wdata = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        pf_re = 1'b1;
        rs_re = 1'b1;  // up: same slot, written two rows back
      end
      ST_RD_CTR: begin
        rs_re    = 1'b1;
        rs_raddr = {~slot, col_q};
      end
      ST_RD_RIGHT: begin
        pf_we    = te_item_q;
        rs_re    = 1'b1;
        rs_raddr = {~slot, col_q + COL_W'(1)};
      end
      ST_RESULT: begin
        res_go = (row_q == '0) || out_free;
        rs_we  = res_go;
      end
      ST_FL_RD: begin
        rs_re    = 1'b1;
        rs_raddr = {LAST_SLOT, fl_x_q};
      end
      ST_FL_OUT: fl_go = out_free;
      default: ;
    endcase
  end

  always_comb begin
    blend_px.r = blend8(cur_q.r, pf_rdata.r);
    blend_px.g = blend8(cur_q.g, pf_rdata.g);
    blend_px.b = blend8(cur_q.b, pf_rdata.b);
    blur_px.r  = blur8(ctr_q.r, up_q.r, val_q.r, left_q.r, rs_rdata.r);
    blur_px.g  = blur8(ctr_q.g, up_q.g, val_q.g, left_q.g, rs_rdata.g);
    blur_px.b  = blur8(ctr_q.b, up_q.b, val_q.b, left_q.b, rs_rdata.b);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pix_q       <= '0;
      fl_x_q      <= '0;
      te_q        <= 1'b1;
      se_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + PIX_W'(1);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TEMPORAL: te_q <= cfg_data_i;
          CFG_SPATIAL:  se_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (res_go) begin
        if (last_pix) begin
          col_q <= '0;
          row_q <= '0;
          pix_q <= '0;
        end else begin
          pix_q <= pix_q + PIX_W'(1);
          if (col_q == LAST_COL) begin
            col_q <= '0;
            row_q <= row_q + ROW_W'(1);
          end else begin
            col_q <= col_q + COL_W'(1);
          end
        end
      end
      if (fl_go) fl_x_q <= (fl_x_q == LAST_COL) ? '0 : fl_x_q + COL_W'(1);
      if ((res_go && row_q != '0) || fl_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      cur_q     <= rgb_t'(s_axis_tdata);
      te_item_q <= te_q;
    end
    if (state_q == ST_RD_CTR) up_q <= rs_rdata;
    if (state_q == ST_RD_RIGHT) begin
      ctr_q <= rs_rdata;
      val_q <= te_item_q ? blend_px : cur_q;
    end
    if (res_go) left_q <= ctr_q;
    if (res_go && row_q != '0) begin
      out_px_q   <= interior ? blur_px : ctr_q;
      out_last_q <= 1'b0;
    end else if (fl_go) begin
      out_px_q   <= rs_rdata;
      out_last_q <= (fl_x_q == LAST_COL);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_px_q;
  assign m_axis_tlast  = out_last_q;

  // frame end only once the flush column has wrapped
  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> (fl_x_q == '0))
    else $error("frame end with flush column not wrapped");

  // linear pixel address tracks row and column
  a_pix_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pix_q) == 32'(row_q) * WIDTH + 32'(col_q))
    else $error("pixel address out of step with position");

  // nothing leaves during the clearing pass
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !m_axis_tvalid && !s_axis_tready)
    else $error("traffic during clearing pass");

endmodule

`default_nettype wire

// ===== rtl/rgbsm_ram.sv =====
// ----------------------------------------------------------------------------
// rgbsm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbsm_ram #(
  parameter int unsigned DATA_W = 24,
  parameter int unsigned DEPTH  = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
